>>> design/integer_matrix_multiply_core_assert.svh
// Assertion macros used by the checker file of the matrix multiply core.
`ifndef INTEGER_MATRIX_MULTIPLY_CORE_ASSERT_SVH
`define INTEGER_MATRIX_MULTIPLY_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk and muted while arst_n is low.
`define IMM_ASSERT_IMPL(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("matrix multiply port assertion failed");

// Next-cycle implication, sampled on clk and muted while arst_n is low.
`define IMM_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("matrix multiply port assertion failed");

`endif

>>> design/imm_pkg.sv
// Shared types and fixed field widths of the matrix multiply core.
`default_nettype none

package imm_pkg;

	localparam int ROW_W      = 2;
	localparam int VALUE_W    = 16;
	localparam int PRODUCT_W  = 34;
	localparam int IN_DATA_W  = 24;
	localparam int OUT_DATA_W = 40;
	localparam int QDEPTH     = 4;

	// One classified input beat as it waits for the back end.
	typedef struct packed {
		logic               wr;
		logic               sel_b;
		logic               start;
		logic [ROW_W-1:0]   row;
		logic [ROW_W-1:0]   col;
		logic [VALUE_W-1:0] value;
	} imm_cmd_t;

endpackage

`default_nettype wire

>>> design/imm_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module imm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

>>> design/imm_front.sv
// Front end: accepts input beats, classifies them and queues them for the back end.
`default_nettype none

module imm_front import imm_pkg::*; #(
	parameter int DIM       = 4,
	parameter int ELEM_BITS = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic               action,
	input  wire logic [ROW_W-1:0]   row,
	input  wire logic [ROW_W-1:0]   col,
	input  wire logic [VALUE_W-1:0] value,
	input  wire logic               start_req,
	output logic                    cmd_valid,
	output imm_cmd_t                cmd,
	input  wire logic               cmd_pop
);

	localparam int EW  = (ELEM_BITS < VALUE_W) ? ELEM_BITS : VALUE_W;
	localparam int QPW = $clog2(QDEPTH);
	localparam int QCW = $clog2(QDEPTH + 1);

	imm_cmd_t       cmd_in;
	imm_cmd_t       queue_q [QDEPTH];
	logic [QPW-1:0] wr_ptr_q;
	logic [QPW-1:0] rd_ptr_q;
	logic [QCW-1:0] count_q;
	logic           push;

	// A write outside the matrix is dropped, but its start request still counts.
	always_comb begin
		cmd_in.wr    = (32'(row) < DIM) && (32'(col) < DIM);
		cmd_in.sel_b = action;
		cmd_in.start = start_req;
		cmd_in.row   = row;
		cmd_in.col   = col;
		cmd_in.value = VALUE_W'($signed(value[EW-1:0]));
	end

	assign in_ready  = (count_q != QCW'(QDEPTH));
	assign push      = in_valid && in_ready;
	assign cmd_valid = (count_q != '0);
	assign cmd       = queue_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= cmd_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (cmd_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !cmd_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push && cmd_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

>>> design/imm_back.sv
// Back end: matrix storage, multiply-accumulate sequencer and result register.
`default_nettype none

module imm_back import imm_pkg::*; #(
	parameter int DIM       = 4,
	parameter int ELEM_BITS = 16
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cmd_valid,
	input  wire imm_cmd_t             cmd,
	output logic                      cmd_pop,
	output logic                      res_valid,
	input  wire logic                 res_ready,
	output logic      [ROW_W-1:0]     res_row,
	output logic      [ROW_W-1:0]     res_col,
	output logic      [PRODUCT_W-1:0] res_product,
	output logic                      res_final
);

	localparam int EW    = (ELEM_BITS < VALUE_W) ? ELEM_BITS : VALUE_W;
	localparam int CW    = $clog2(DIM);
	localparam int NE    = DIM * DIM;
	localparam int AW    = $clog2(NE);
	localparam int PW    = 2 * EW;
	localparam int ACC_W = PW + CW + 1;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_RUN  = 1'b1;

	localparam logic [CW-1:0] LAST = CW'(DIM - 1);

	logic          state_q;
	logic [CW-1:0] i_q;
	logic [CW-1:0] j_q;
	logic [CW-1:0] k_q;
	logic          adv;
	logic          issue;
	logic          we_a;
	logic          we_b;
	logic [AW-1:0] waddr;
	logic [AW-1:0] raddr_a;
	logic [AW-1:0] raddr_b;
	logic [NE-1:0] a_vld_q;
	logic [NE-1:0] b_vld_q;
	logic [EW-1:0] a_rdata;
	logic [EW-1:0] b_rdata;

	logic             vld_s1;
	logic             first_s1;
	logic             last_s1;
	logic             fin_s1;
	logic             a_ok_s1;
	logic             b_ok_s1;
	logic [ROW_W-1:0] row_s1;
	logic [ROW_W-1:0] col_s1;

	logic                 vld_s2;
	logic                 first_s2;
	logic                 last_s2;
	logic                 fin_s2;
	logic [ROW_W-1:0]     row_s2;
	logic [ROW_W-1:0]     col_s2;
	logic signed [PW-1:0] prod_s2;

	logic signed [EW-1:0]    opa;
	logic signed [EW-1:0]    opb;
	logic signed [ACC_W-1:0] acc_q;
	logic signed [ACC_W-1:0] acc_base;
	logic signed [ACC_W-1:0] sum;

	logic                 res_valid_q;
	logic [ROW_W-1:0]     res_row_q;
	logic [ROW_W-1:0]     res_col_q;
	logic [PRODUCT_W-1:0] res_product_q;
	logic                 res_final_q;

	// The whole compute pipeline moves only when the result register can take a beat.
	assign adv     = !res_valid_q || res_ready;
	assign cmd_pop = (state_q == ST_IDLE) && cmd_valid;
	assign issue   = (state_q == ST_RUN) && adv;

	assign we_a    = cmd_pop && cmd.wr && !cmd.sel_b;
	assign we_b    = cmd_pop && cmd.wr && cmd.sel_b;
	assign waddr   = AW'(32'(cmd.row) * DIM + 32'(cmd.col));
	assign raddr_a = AW'(32'(i_q) * DIM + 32'(k_q));
	assign raddr_b = AW'(32'(k_q) * DIM + 32'(j_q));

	imm_ram #(
		.WIDTH (EW),
		.DEPTH (NE)
	) u_ram_a (
		.clk   (clk),
		.we    (we_a),
		.waddr (waddr),
		.wdata (cmd.value[EW-1:0]),
		.re    (issue),
		.raddr (raddr_a),
		.rdata (a_rdata)
	);

	imm_ram #(
		.WIDTH (EW),
		.DEPTH (NE)
	) u_ram_b (
		.clk   (clk),
		.we    (we_b),
		.waddr (waddr),
		.wdata (cmd.value[EW-1:0]),
		.re    (issue),
		.raddr (raddr_b),
		.rdata (b_rdata)
	);

	// Entries never written since reset read as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_vld_q <= '0;
			b_vld_q <= '0;
		end else begin
			if (we_a) begin
				a_vld_q[waddr] <= 1'b1;
			end
			if (we_b) begin
				b_vld_q[waddr] <= 1'b1;
			end
		end
	end

	// Walks k fastest, then the column, then the row of the product.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			i_q     <= '0;
			j_q     <= '0;
			k_q     <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_pop && cmd.start) begin
						state_q <= ST_RUN;
						i_q     <= '0;
						j_q     <= '0;
						k_q     <= '0;
					end
				end
				ST_RUN: begin
					if (adv) begin
						if (k_q == LAST) begin
							k_q <= '0;
							if (j_q == LAST) begin
								j_q <= '0;
								if (i_q == LAST) begin
									i_q     <= '0;
									state_q <= ST_IDLE;
								end else begin
									i_q <= i_q + 1'b1;
								end
							end else begin
								j_q <= j_q + 1'b1;
							end
						end else begin
							k_q <= k_q + 1'b1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1      <= 1'b0;
			vld_s2      <= 1'b0;
			res_valid_q <= 1'b0;
		end else if (adv) begin
			vld_s1      <= issue;
			vld_s2      <= vld_s1;
			res_valid_q <= vld_s2 && last_s2;
		end
	end

	assign opa      = a_ok_s1 ? $signed(a_rdata) : '0;
	assign opb      = b_ok_s1 ? $signed(b_rdata) : '0;
	assign acc_base = first_s2 ? '0 : acc_q;
	assign sum      = acc_base + ACC_W'(prod_s2);

	always_ff @(posedge clk) begin
		if (adv) begin
			first_s1 <= (k_q == '0);
			last_s1  <= (k_q == LAST);
			fin_s1   <= (i_q == LAST) && (j_q == LAST);
			a_ok_s1  <= a_vld_q[raddr_a];
			b_ok_s1  <= b_vld_q[raddr_b];
			row_s1   <= ROW_W'(i_q);
			col_s1   <= ROW_W'(j_q);

			first_s2 <= first_s1;
			last_s2  <= last_s1;
			fin_s2   <= fin_s1;
			row_s2   <= row_s1;
			col_s2   <= col_s1;
			prod_s2  <= opa * opb;

			if (vld_s2) begin
				acc_q <= sum;
				if (last_s2) begin
					res_row_q     <= row_s2;
					res_col_q     <= col_s2;
					res_product_q <= PRODUCT_W'(sum);
					res_final_q   <= fin_s2;
				end
			end
		end
	end

	assign res_valid   = res_valid_q;
	assign res_row     = res_row_q;
	assign res_col     = res_col_q;
	assign res_product = res_product_q;
	assign res_final   = res_final_q;

endmodule

`default_nettype wire

>>> design/integer_matrix_multiply_core.sv
// Square signed integer matrix multiplier with stream ports.
//
// Input beats write one entry of A (tuser = 0) or B (tuser = 1) at the row and
// column in tdata. A beat with tlast set asks for C = A times B once its write
// is done. The block answers with DIM*DIM output beats in row-major order, each
// carrying row, column and the full-width dot product; tlast marks the last.
// Input beats pass through a four-entry queue and are accepted one per cycle
// while it has room. Write beats leave the queue one per cycle while no product
// runs. A product is computed by the single multiply-accumulate unit, which
// reads one entry of A and one of B per cycle while the output is not stalled;
// each output beat follows its last reads through the RAM read data and s1
// registers, the product register and the result register. While the product
// runs, later beats wait in the queue and tready falls once it is full. A stalled
// output holds its beat and freezes the whole compute pipeline.
// Reset empties the queue and makes every entry of A and B read as zero.
`default_nettype none

module integer_matrix_multiply_core import imm_pkg::*; #(
	parameter int DIM       = 4,
	parameter int ELEM_BITS = 16
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_axis_tvalid,
	output logic                       s_axis_tready,
	// row [1:0], col [3:2], value [19:4], zero fill [23:20]
	input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
	// action
	input  wire logic                  s_axis_tuser,
	input  wire logic                  s_axis_tlast,
	output logic                       m_axis_tvalid,
	input  wire logic                  m_axis_tready,
	// out_row [1:0], out_col [3:2], product [37:4], zero fill [39:38]
	output logic      [OUT_DATA_W-1:0] m_axis_tdata,
	output logic                       m_axis_tlast
);

	imm_cmd_t             cmd;
	logic                 cmd_valid;
	logic                 cmd_pop;
	logic [ROW_W-1:0]     res_row;
	logic [ROW_W-1:0]     res_col;
	logic [PRODUCT_W-1:0] res_product;

	imm_front #(
		.DIM       (DIM),
		.ELEM_BITS (ELEM_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.action    (s_axis_tuser),
		.row       (s_axis_tdata[1:0]),
		.col       (s_axis_tdata[3:2]),
		.value     (s_axis_tdata[19:4]),
		.start_req (s_axis_tlast),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop)
	);

	imm_back #(
		.DIM       (DIM),
		.ELEM_BITS (ELEM_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_valid   (cmd_valid),
		.cmd         (cmd),
		.cmd_pop     (cmd_pop),
		.res_valid   (m_axis_tvalid),
		.res_ready   (m_axis_tready),
		.res_row     (res_row),
		.res_col     (res_col),
		.res_product (res_product),
		.res_final   (m_axis_tlast)
	);

	assign m_axis_tdata = {2'b00, res_product, res_col, res_row};

endmodule

`default_nettype wire

>>> design/imm_checker.sv
// Port-level checker for the matrix multiply core and its bind.
`default_nettype none
`include "integer_matrix_multiply_core_assert.svh"

module imm_checker import imm_pkg::*; #(
	parameter int DIM = 4
) (
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  m_axis_tvalid,
	input wire logic                  m_axis_tready,
	input wire logic [OUT_DATA_W-1:0] m_axis_tdata,
	input wire logic                  m_axis_tlast
);

	// A stalled output beat stays up and unchanged.
	`IMM_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))

	// The marked beat is always the bottom-right entry of the product.
	`IMM_ASSERT_IMPL(a_last_pos, m_axis_tvalid && m_axis_tlast, m_axis_tdata[1:0] == 2'(DIM - 1) && m_axis_tdata[3:2] == 2'(DIM - 1))

	// A new product cannot start showing right after the last beat is taken.
	`IMM_ASSERT_NEXT(a_last_gap, m_axis_tvalid && m_axis_tready && m_axis_tlast, !m_axis_tvalid)

endmodule

bind integer_matrix_multiply_core imm_checker #(
	.DIM (DIM)
) u_imm_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
